@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands for the compositor RTL, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("compositor assertion failed");

// Next-cycle implication.
`define SPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("compositor assertion failed");

`endif

@@ rtl/core/spc_pkg.sv @@
// ----------------------------------------------------------------------------
// spc_pkg
// Beat types, register codes and blend constants for the sprite compositor.
// ----------------------------------------------------------------------------
package spc_pkg;

  typedef struct packed {
    logic [7:0] src_c0;
    logic [7:0] src_c1;
    logic [7:0] src_c2;
    logic [7:0] src_alpha;
    logic [7:0] dst_c0;
    logic [7:0] dst_c1;
    logic [7:0] dst_c2;
  } spc_in_t;

  typedef struct packed {
    logic [7:0] out_c0;
    logic [7:0] out_c1;
    logic [7:0] out_c2;
    logic       written;
  } spc_out_t;

  // How the two weighted products are reduced to a channel.
  typedef enum logic {
    OP_SUM,    // floor of the summed products
    OP_FLOOR   // sum of the separately floored products
  } spc_op_t;

  typedef struct packed {
    logic    adv2;
    logic    adv3;
    spc_op_t op;
  } spc_ctrl_t;

  localparam logic [1:0] REG_BLEND_MODE  = 2'd0;
  localparam logic [1:0] REG_SPRITE_FADE = 2'd1;
  localparam logic [1:0] REG_SCREEN_FADE = 2'd2;

  localparam logic [2:0] MODE_COPY      = 3'd0;
  localparam logic [2:0] MODE_ALPHA_KEY = 3'd1;
  localparam logic [2:0] MODE_BLEND     = 3'd2;
  localparam logic [2:0] MODE_FADE_MIX  = 3'd3;
  localparam logic [2:0] MODE_SCREEN    = 3'd4;

  localparam logic [2:0] BLEND_MODE_RST  = MODE_BLEND;
  localparam logic [7:0] SPRITE_FADE_RST = 8'd255;
  localparam logic [8:0] SCREEN_FADE_RST = 9'd256;

  // Weight of one (256 over 256): multiplying by it and dropping 8 bits copies.
  localparam logic [8:0] FULL_WEIGHT = 9'd256;

endpackage

@@ rtl/core/spc_chan.sv @@
// ----------------------------------------------------------------------------
// spc_chan
// One colour channel: weighted products in stage 2, reduction in stage 3.
// ----------------------------------------------------------------------------
module spc_chan
  import spc_pkg::*;
(
  input  logic       clk,
  input  spc_ctrl_t  ctrl,
  input  logic [7:0] src,
  input  logic [7:0] dst,
  input  logic [8:0] ws,
  input  logic [8:0] wd,
  output logic [7:0] res
);

  logic [16:0] p_r, p_nxt;
  logic [16:0] q_r, q_nxt;
  logic [7:0]  res_r, res_nxt;
  logic [17:0] sum;

  assign p_nxt = {9'b0, src} * {8'b0, ws};
  assign q_nxt = {9'b0, dst} * {8'b0, wd};
  assign sum   = {1'b0, p_r} + {1'b0, q_r};

  always_comb begin
    unique case (ctrl.op)
      OP_SUM:   res_nxt = sum[15:8];
      OP_FLOOR: res_nxt = p_r[15:8] + q_r[15:8];
      default:  res_nxt = sum[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv2) begin
      p_r <= p_nxt;
      q_r <= q_nxt;
    end
    if (ctrl.adv3) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ rtl/core/sprite_pixel_compositor_core.sv @@
// An accepted input beat reaches out_ through the stage 1, 2 and 3 registers.
// Throughput: one pixel per cycle while out_stall is low; the three stages
// (weight, multiply, reduce) each take a new beat whenever the stage after them moves.
// Reset (rst_n low, synchronous): pipeline emptied, blend_mode = 2,
// sprite_fade = 255, screen_fade = 256.
// ----------------------------------------------------------------------------
// sprite_pixel_compositor_core
// RGBA8 sprite-over-framebuffer compositor with copy, key, blend, faded blend
// and screen fade modes, behind an APB-style register port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sprite_pixel_compositor_core
  import spc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  spc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output spc_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [2:0] blend_mode_r;
  logic [7:0] sprite_fade_r;
  logic [8:0] screen_fade_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r  <= BLEND_MODE_RST;
      sprite_fade_r <= SPRITE_FADE_RST;
      screen_fade_r <= SCREEN_FADE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BLEND_MODE:  blend_mode_r  <= pwdata[2:0];
        REG_SPRITE_FADE: sprite_fade_r <= pwdata[7:0];
        REG_SCREEN_FADE: screen_fade_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BLEND_MODE:  prdata = {29'b0, blend_mode_r};
      REG_SPRITE_FADE: prdata = {24'b0, sprite_fade_r};
      REG_SCREEN_FADE: prdata = {23'b0, screen_fade_r};
      default:         prdata = 32'b0;
    endcase
  end

  // Stage handshake: a stage loads when it is empty or its successor moves
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage 1: pick weights for source and destination
  logic [15:0] fade_prod;
  logic [7:0]  faded_a;
  logic [8:0]  scr_f;
  logic        a_nz;
  logic [8:0]  ws_nxt, wd_nxt;
  spc_op_t     op_nxt;
  logic        wr_nxt;

  assign fade_prod = {8'b0, sprite_fade_r} * {8'b0, in_data.src_alpha};
  assign faded_a   = fade_prod[15:8];
  assign scr_f     = (screen_fade_r > FULL_WEIGHT) ? FULL_WEIGHT : screen_fade_r;
  assign a_nz      = (in_data.src_alpha != 8'd0);

  always_comb begin
    // default: keep the destination
    ws_nxt = 9'd0;
    wd_nxt = FULL_WEIGHT;
    op_nxt = OP_SUM;
    wr_nxt = 1'b0;
    unique case (blend_mode_r)
      MODE_COPY: begin
        ws_nxt = FULL_WEIGHT;
        wd_nxt = 9'd0;
        wr_nxt = 1'b1;
      end
      MODE_ALPHA_KEY: begin
        if (a_nz) begin
          ws_nxt = FULL_WEIGHT;
          wd_nxt = 9'd0;
          wr_nxt = 1'b1;
        end
      end
      MODE_BLEND: begin
        if (a_nz) begin
          ws_nxt = {1'b0, in_data.src_alpha};
          wd_nxt = {1'b0, ~in_data.src_alpha};
          wr_nxt = 1'b1;
        end
      end
      MODE_FADE_MIX: begin
        if (a_nz) begin
          ws_nxt = {1'b0, faded_a};
          wd_nxt = {1'b0, ~faded_a};
          op_nxt = OP_FLOOR;
          wr_nxt = 1'b1;
        end
      end
      MODE_SCREEN: begin
        ws_nxt = 9'd0;
        wd_nxt = scr_f;
        wr_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  spc_in_t    s1_pix_r;
  logic [8:0] s1_ws_r, s1_wd_r;
  spc_op_t    s1_op_r, s2_op_r;
  logic       s1_wr_r, s2_wr_r, s3_wr_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_pix_r <= in_data;
      s1_ws_r  <= ws_nxt;
      s1_wd_r  <= wd_nxt;
      s1_op_r  <= op_nxt;
      s1_wr_r  <= wr_nxt;
    end
    if (rdy2) begin
      s2_op_r <= s1_op_r;
      s2_wr_r <= s1_wr_r;
    end
    if (rdy3) begin
      s3_wr_r <= s2_wr_r;
    end
  end

  // Stages 2 and 3: per-channel datapath
  spc_ctrl_t  ctrl;
  logic [7:0] res0, res1, res2;

  assign ctrl.adv2 = rdy2;
  assign ctrl.adv3 = rdy3;
  assign ctrl.op   = s2_op_r;

  spc_chan u_chan0 (
    .clk  (clk),
    .ctrl (ctrl),
    .src  (s1_pix_r.src_c0),
    .dst  (s1_pix_r.dst_c0),
    .ws   (s1_ws_r),
    .wd   (s1_wd_r),
    .res  (res0)
  );

  spc_chan u_chan1 (
    .clk  (clk),
    .ctrl (ctrl),
    .src  (s1_pix_r.src_c1),
    .dst  (s1_pix_r.dst_c1),
    .ws   (s1_ws_r),
    .wd   (s1_wd_r),
    .res  (res1)
  );

  spc_chan u_chan2 (
    .clk  (clk),
    .ctrl (ctrl),
    .src  (s1_pix_r.src_c2),
    .dst  (s1_pix_r.dst_c2),
    .ws   (s1_ws_r),
    .wd   (s1_wd_r),
    .res  (res2)
  );

  assign out_valid        = v3_r;
  assign out_data.out_c0  = res0;
  assign out_data.out_c1  = res1;
  assign out_data.out_c2  = res2;
  assign out_data.written = s3_wr_r;

  // Input is held back only when every stage is full and the output stalls
  `SPC_ASSERT_IMP(a_stall_full, in_stall, v1_r && v2_r && v3_r && out_stall)
  // Weights never exceed unity, so the products cannot overflow a channel
  `SPC_ASSERT_IMP(a_weight_sum, v1_r, ({1'b0, s1_ws_r} + {1'b0, s1_wd_r}) <= 10'd256)
  // Separately floored reduction only arises from a written pixel
  `SPC_ASSERT_IMP(a_floor_wr, v1_r && (s1_op_r == OP_FLOOR), s1_wr_r)
  // An accepted beat lands in stage 1
  `SPC_ASSERT_NXT(a_accept_s1, in_valid && !in_stall, v1_r)

endmodule

@@ tb/sv/tb_sprite_pixel_compositor_core.sv @@
// ----------------------------------------------------------------------------
// tb_sprite_pixel_compositor_core
// Drives source and destination pixels through the compositor under every
// blend mode and a range of fade settings. A scoreboard predicts each output
// pixel from the current register values and checks every output beat in
// order, while both channel ends idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sprite_pixel_compositor_core
  import spc_pkg::*;
();

  localparam int STALL_LIMIT  = 4000;
  localparam int SEGMENTS     = 12;
  localparam int SEGMENT_PIX  = 150;

  class composite_scoreboard;
    logic [2:0] blend_mode;
    logic [7:0] sprite_fade;
    logic [8:0] screen_fade;
    spc_out_t   expected_pixels[$];
    int         errors;

    function new();
      blend_mode  = BLEND_MODE_RST;
      sprite_fade = SPRITE_FADE_RST;
      screen_fade = SCREEN_FADE_RST;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_BLEND_MODE:  blend_mode  = value[2:0];
        REG_SPRITE_FADE: sprite_fade = value[7:0];
        REG_SCREEN_FADE: screen_fade = value[8:0];
        default: ;
      endcase
    endfunction

    function spc_out_t blend_pixel(spc_in_t px);
      int unsigned s[3];
      int unsigned d[3];
      int unsigned r[3];
      int unsigned a;
      int unsigned b;
      int unsigned f;
      spc_out_t    res;
      s[0] = px.src_c0;
      s[1] = px.src_c1;
      s[2] = px.src_c2;
      d[0] = px.dst_c0;
      d[1] = px.dst_c1;
      d[2] = px.dst_c2;
      a = px.src_alpha;
      r = d;
      res.written = 1'b0;
      case (blend_mode)
        MODE_COPY: begin
          r = s;
          res.written = 1'b1;
        end
        MODE_ALPHA_KEY: begin
          if (a != 0) begin
            r = s;
            res.written = 1'b1;
          end
        end
        MODE_BLEND: begin
          if (a != 0) begin
            for (int i = 0; i < 3; i++) r[i] = (s[i] * a + d[i] * (255 - a)) / 256;
            res.written = 1'b1;
          end
        end
        MODE_FADE_MIX: begin
          // transparency is judged on the raw alpha, not the faded one
          if (a != 0) begin
            b = (sprite_fade * a) / 256;
            for (int i = 0; i < 3; i++) r[i] = (s[i] * b) / 256 + (d[i] * (255 - b)) / 256;
            res.written = 1'b1;
          end
        end
        MODE_SCREEN: begin
          f = (screen_fade > FULL_WEIGHT) ? FULL_WEIGHT : screen_fade;
          for (int i = 0; i < 3; i++) r[i] = (d[i] * f) >> 8;
          res.written = 1'b1;
        end
        default: ;
      endcase
      res.out_c0 = 8'(r[0]);
      res.out_c1 = 8'(r[1]);
      res.out_c2 = 8'(r[2]);
      return res;
    endfunction

    function void note_pixel(spc_in_t px);
      expected_pixels.push_back(blend_pixel(px));
    endfunction

    function void check_pixel(spc_out_t got);
      spc_out_t want;
      if (expected_pixels.size() == 0) begin
        $error("output beat with no pixel pending");
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.out_c0 !== want.out_c0) begin
        $error("out_c0: expected %0d, got %0d", want.out_c0, got.out_c0);
        errors++;
      end
      if (got.out_c1 !== want.out_c1) begin
        $error("out_c1: expected %0d, got %0d", want.out_c1, got.out_c1);
        errors++;
      end
      if (got.out_c2 !== want.out_c2) begin
        $error("out_c2: expected %0d, got %0d", want.out_c2, got.out_c2);
        errors++;
      end
      if (got.written !== want.written) begin
        $error("written: expected %0d, got %0d", want.written, got.written);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  spc_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  spc_out_t    out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int idle_cycles     = 0;

  composite_scoreboard pixel_sb = new();

  sprite_pixel_compositor_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) pixel_sb.note_pixel(in_data);
      if (out_valid && !out_stall) pixel_sb.check_pixel(out_data);
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $error("no beat for %0d cycles", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic spc_in_t pixel(input logic [7:0] s0, s1, s2, a, d0, d1, d2);
    spc_in_t px;
    px.src_c0    = s0;
    px.src_c1    = s1;
    px.src_c2    = s2;
    px.src_alpha = a;
    px.dst_c0    = d0;
    px.dst_c1    = d1;
    px.dst_c2    = d2;
    return px;
  endfunction

  function automatic spc_in_t rand_pixel();
    logic [63:0] raw;
    spc_in_t     px;
    int unsigned pick;
    raw  = {$urandom, $urandom};
    px   = raw[55:0];
    pick = $urandom_range(99);
    if (pick < 20) px.src_alpha = 8'd0;
    else if (pick < 32) px.src_alpha = 8'd255;
    else if (pick < 37) px.src_alpha = 8'd1;
    pick = $urandom_range(99);
    if (pick < 6) {px.dst_c0, px.dst_c1, px.dst_c2} = '1;
    else if (pick < 12) {px.src_c0, px.src_c1, px.src_c2} = '1;
    else if (pick < 16) {px.dst_c0, px.dst_c1, px.dst_c2} = '0;
    return px;
  endfunction

  task automatic send_pixel(input spc_in_t px);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the sender until every pixel in flight has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pixel_sb.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(input logic [2:0] mode, input logic [7:0] sfade,
                              input logic [8:0] scr);
    drain_results();
    cfg_write(REG_BLEND_MODE, 32'(mode));
    cfg_write(REG_SPRITE_FADE, 32'(sfade));
    cfg_write(REG_SCREEN_FADE, 32'(scr));
  endtask

  initial begin
    logic [2:0] mode;
    logic [7:0] sfade;
    logic [8:0] scr;
    int unsigned pick;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: alpha blend at full sprite and screen fade
    send_pixel(pixel(255, 128, 0, 0, 10, 20, 30));
    send_pixel(pixel(255, 255, 255, 255, 0, 0, 0));
    send_pixel(pixel(0, 0, 0, 1, 255, 255, 255));
    send_pixel(pixel(200, 100, 50, 128, 50, 100, 200));

    apply_config(MODE_COPY, 8'd255, 9'd256);
    send_pixel(pixel(1, 2, 3, 0, 9, 9, 9));
    send_pixel(pixel(255, 255, 255, 255, 0, 0, 0));

    apply_config(MODE_ALPHA_KEY, 8'd255, 9'd256);
    send_pixel(pixel(77, 88, 99, 0, 1, 2, 3));
    send_pixel(pixel(77, 88, 99, 1, 1, 2, 3));

    apply_config(MODE_FADE_MIX, 8'd255, 9'd256);
    send_pixel(pixel(255, 255, 255, 255, 0, 0, 0));
    send_pixel(pixel(255, 255, 255, 0, 40, 50, 60));
    // faded alpha floors to zero, still a write
    apply_config(MODE_FADE_MIX, 8'd1, 9'd256);
    send_pixel(pixel(255, 0, 128, 200, 100, 255, 7));
    apply_config(MODE_FADE_MIX, 8'd0, 9'd256);
    send_pixel(pixel(255, 255, 255, 255, 255, 255, 255));

    apply_config(MODE_SCREEN, 8'd0, 9'd256);
    send_pixel(pixel(0, 0, 0, 0, 255, 128, 1));
    apply_config(MODE_SCREEN, 8'd0, 9'd0);
    send_pixel(pixel(255, 255, 255, 255, 255, 255, 255));
    apply_config(MODE_SCREEN, 8'd0, 9'd128);
    send_pixel(pixel(9, 9, 9, 9, 255, 3, 200));
    // fade above one saturates
    apply_config(MODE_SCREEN, 8'd0, 9'd511);
    send_pixel(pixel(9, 9, 9, 9, 255, 254, 1));

    // unused modes leave the destination alone
    apply_config(3'd5, 8'd255, 9'd256);
    send_pixel(pixel(255, 255, 255, 255, 1, 2, 3));
    apply_config(3'd6, 8'd255, 9'd256);
    send_pixel(pixel(0, 0, 0, 0, 200, 201, 202));
    apply_config(3'd7, 8'd255, 9'd256);
    send_pixel(pixel(128, 128, 128, 128, 0, 255, 0));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      pick = $urandom_range(99);
      mode = (pick < 8) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
      pick = $urandom_range(99);
      if (pick < 15) sfade = 8'd0;
      else if (pick < 30) sfade = 8'd255;
      else if (pick < 38) sfade = 8'd1;
      else sfade = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 15) scr = 9'd0;
      else if (pick < 30) scr = 9'd256;
      else if (pick < 38) scr = 9'd255;
      else if (pick < 48) scr = 9'($urandom_range(511, 257));
      else scr = 9'($urandom_range(256));
      apply_config(mode, sfade, scr);

      case (seg % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin sender_idle_pct = 6; recv_stall_pct = 6; end
      endcase

      for (int n = 0; n < SEGMENT_PIX; n++) send_pixel(rand_pixel());
    end

    drain_results();
    if (pixel_sb.errors == 0 && pixel_sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
